### hw/rtl/ffra_pkg.sv
// Shared types and constants of the first-fit range allocator.
// Used by ffra_cell and first_fit_range_allocator_unit.
package ffra_pkg;

    localparam int MAX_RANGES = 64;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    localparam logic [31:0] POOL_RESET = 32'd268435456;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOSPC  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
    } t_range;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SETLEN,
        CELL_TAKE_LEFT,
        CELL_TAKE_RIGHT
    } t_cell_op;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_CAPTURE,
        SH_SHIFT
    } t_sh_op;

    typedef struct packed {
        t_cell_op op;
        t_range   data;
        t_sh_op   sh_op;
    } t_cell_cmd;

endpackage

### hw/rtl/ffra_cell.sv
// One cell of the range table: a stored free range plus its scan copy.
// Depends on ffra_pkg for the range and command types.
module ffra_cell (
    input  logic              i_clk,
    input  ffra_pkg::t_cell_cmd i_cmd,
    input  ffra_pkg::t_range  i_left,
    input  ffra_pkg::t_range  i_right,
    input  ffra_pkg::t_range  i_sh_right,
    output ffra_pkg::t_range  o_main,
    output ffra_pkg::t_range  o_shadow
);
    import ffra_pkg::*;

    t_range r_main;
    t_range r_shadow;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CELL_LOAD:       r_main <= i_cmd.data;
            CELL_SETLEN:     r_main.len <= i_cmd.data.len;
            CELL_TAKE_LEFT:  r_main <= i_left;
            CELL_TAKE_RIGHT: r_main <= i_right;
            default:         r_main <= r_main;
        endcase
        case (i_cmd.sh_op)
            SH_CAPTURE: r_shadow <= r_main;
            SH_SHIFT:   r_shadow <= i_sh_right;
            default:    r_shadow <= r_shadow;
        endcase
    end

    assign o_main   = r_main;
    assign o_shadow = r_shadow;

endmodule

### hw/rtl/ffra_mod.sv
// Bit-serial restoring remainder unit, one quotient bit per cycle.
// Depends on nothing beyond plain logic.
module ffra_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_rem
);
    logic [32:0] r_rem;
    logic [31:0] r_num;
    logic [31:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] n_try;
    logic [32:0] n_rem;

    always_comb begin
        n_try = {r_rem[31:0], r_num[31]};
        n_rem = (n_try >= {1'b0, r_den}) ? (n_try - {1'b0, r_den}) : n_try;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_rem  <= 33'd0;
                r_num  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= {r_num[30:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[31:0];

endmodule

### hw/rtl/first_fit_range_allocator_unit.sv
// First-fit range allocator: top level with sequencer, cell row and result register.
// Depends on ffra_pkg, ffra_cell and ffra_mod.
//
// Keeps up to 64 free ranges in a row of cells ordered by start offset. One
// request is taken at a time. On each request the row is copied into a scan line
// that moves one range past the sequencer for each range inspected. An allocate
// finds the alignment remainder of each range with a mask when the alignment is a
// power of two (or zero), and with the bit-serial remainder unit otherwise.
// Inserts and removals move the whole row at once. The result register lets a new
// request enter while the last result waits. Writing pool_size resets the table to
// one range (none if the size is zero); a write is taken only while no request is
// in progress, and a pending write stalls the input channel.
module first_fit_range_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [31:0] i_req_size,
    input  logic [31:0] i_alignment,
    input  logic [31:0] i_release_offset,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_offset,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import ffra_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_MODW, S_CHECK, S_FSCAN, S_FEND, S_RESULT
    } t_state;

    t_state            r_state;
    logic [31:0]       r_size;
    logic [31:0]       r_align;
    logic [31:0]       r_off;
    logic [32:0]       r_end;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_last;
    logic [31:0]       r_last_len;
    logic              r_merged;
    logic [31:0]       r_mod;
    logic [1:0]        r_res_status;
    logic [31:0]       r_res_off;
    logic              r_out_valid;
    logic [1:0]        r_status;
    logic [31:0]       r_result_offset;

    t_range main_q   [MAX_RANGES];
    t_range shadow_q [MAX_RANGES];
    t_cell_cmd cmd   [MAX_RANGES];

    logic in_acc, cfg_we;
    t_range head;
    logic [32:0] head_end;
    logic align_pow2;
    logic [31:0] pad;
    logic [32:0] need;
    logic fit;
    logic [31:0] rest_start, rest_len;
    logic hit_left, hit_right, table_full;
    logic [32:0] in_end;
    logic mod_start, mod_done;
    logic [31:0] mod_rem;

    // table edit controls
    logic             e_wr, e_ins, e_del;
    t_cell_op         e_wr_op;
    logic [CNT_W-1:0] e_wr_pos, e_apos;
    t_range           e_wr_data, e_ins_data;
    t_sh_op           e_sh;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign cfg_we     = i_cfg_valid && (r_state == S_IDLE);
    assign head       = shadow_q[0];
    assign head_end   = {1'b0, head.start} + {1'b0, head.len};
    assign align_pow2 = ((r_align & (r_align - 32'd1)) == 32'd0);
    assign pad        = (r_mod != 32'd0) ? (r_align - r_mod) : 32'd0;
    assign need       = {1'b0, r_size} + {1'b0, pad};
    assign fit        = ({1'b0, head.len} >= need);
    assign rest_start = head.start + need[31:0];
    assign rest_len   = head.len - need[31:0];
    assign hit_left   = (head_end == {1'b0, r_off});
    assign hit_right  = ({1'b0, head.start} == r_end);
    assign table_full = (r_count >= CNT_W'(MAX_RANGES));
    assign in_end     = {1'b0, i_release_offset} + {1'b0, i_req_size};
    assign mod_start  = (r_state == S_SCAN) && (r_idx < r_count) && !align_pow2;

    ffra_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_num   (head.start),
        .i_den   (r_align),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    always_comb begin
        e_wr       = 1'b0;
        e_wr_op    = CELL_LOAD;
        e_wr_pos   = r_idx;
        e_wr_data  = head;
        e_ins      = 1'b0;
        e_del      = 1'b0;
        e_apos     = r_idx;
        e_ins_data = '{start: rest_start, len: rest_len};
        e_sh       = SH_HOLD;
        if (!i_rst_n) begin
            e_wr      = 1'b1;
            e_wr_pos  = '0;
            e_wr_data = '{start: 32'd0, len: POOL_RESET};
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (cfg_we) begin
                        e_wr      = 1'b1;
                        e_wr_pos  = '0;
                        e_wr_data = '{start: 32'd0, len: i_cfg_data};
                    end else if (in_acc) begin
                        e_sh = SH_CAPTURE;
                    end
                end
                S_CHECK: begin
                    if (fit) begin
                        if (pad != 32'd0 && rest_len != 32'd0) begin
                            if (!table_full) begin
                                e_wr      = 1'b1;
                                e_wr_data = '{start: head.start, len: pad};
                                e_ins     = 1'b1;
                                e_apos    = r_idx + CNT_W'(1);
                            end
                        end else if (pad != 32'd0) begin
                            e_wr      = 1'b1;
                            e_wr_data = '{start: head.start, len: pad};
                        end else if (rest_len != 32'd0) begin
                            e_wr      = 1'b1;
                            e_wr_data = '{start: rest_start, len: rest_len};
                        end else begin
                            e_del = 1'b1;
                        end
                    end else begin
                        e_sh = SH_SHIFT;
                    end
                end
                S_FSCAN: begin
                    if (r_idx < r_count) begin
                        if (hit_left) begin
                            e_wr      = 1'b1;
                            e_wr_op   = CELL_SETLEN;
                            e_wr_data = '{start: head.start, len: head.len + r_size};
                            e_sh      = SH_SHIFT;
                        end else if (hit_right) begin
                            e_wr = 1'b1;
                            if (r_merged) begin
                                e_wr_op   = CELL_SETLEN;
                                e_wr_pos  = r_last;
                                e_wr_data = '{start: head.start, len: r_last_len + head.len};
                                e_del     = 1'b1;
                            end else begin
                                e_wr_data = '{start: r_off, len: head.len + r_size};
                            end
                        end else begin
                            e_sh = SH_SHIFT;
                        end
                    end
                end
                S_FEND: begin
                    if (!r_merged && !table_full) begin
                        e_ins      = 1'b1;
                        e_apos     = r_pos;
                        e_ins_data = '{start: r_off, len: r_size};
                    end
                end
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
        localparam logic [CNT_W-1:0] K = CNT_W'(k);
        localparam int KL = (k == 0) ? 0 : k - 1;
        localparam int KR = (k == MAX_RANGES - 1) ? k : k + 1;

        always_comb begin
            cmd[k].op    = CELL_HOLD;
            cmd[k].data  = e_wr_data;
            cmd[k].sh_op = e_sh;
            if (e_ins && K > e_apos) begin
                cmd[k].op = CELL_TAKE_LEFT;
            end else if (e_ins && K == e_apos) begin
                cmd[k].op   = CELL_LOAD;
                cmd[k].data = e_ins_data;
            end else if (e_del && K >= e_apos) begin
                cmd[k].op = CELL_TAKE_RIGHT;
            end else if (e_wr && K == e_wr_pos) begin
                cmd[k].op = e_wr_op;
            end
        end

        ffra_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cmd[k]),
            .i_left     (main_q[KL]),
            .i_right    (main_q[KR]),
            .i_sh_right (shadow_q[KR]),
            .o_main     (main_q[k]),
            .o_shadow   (shadow_q[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && r_state != S_RESULT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (cfg_we) begin
                        r_count <= (i_cfg_data == 32'd0) ? '0 : CNT_W'(1);
                    end else if (in_acc) begin
                        r_size     <= i_req_size;
                        r_align    <= (i_alignment == 32'd0) ? 32'd1 : i_alignment;
                        r_off      <= i_release_offset;
                        r_end      <= in_end;
                        r_idx      <= '0;
                        r_pos      <= '0;
                        r_merged   <= 1'b0;
                        r_res_off  <= 32'd0;
                        r_res_status <= ST_OK;
                        if (i_kind == KIND_ALLOC) begin
                            r_state <= S_SCAN;
                        end else if (i_req_size == 32'd0) begin
                            r_state <= S_RESULT;
                        end else if (in_end[32]) begin
                            r_res_status <= ST_NOSPC;
                            r_state      <= S_RESULT;
                        end else begin
                            r_state <= S_FSCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx >= r_count) begin
                        r_res_status <= ST_NOSPC;
                        r_state      <= S_RESULT;
                    end else if (align_pow2) begin
                        r_mod   <= head.start & (r_align - 32'd1);
                        r_state <= S_CHECK;
                    end else begin
                        r_state <= S_MODW;
                    end
                end
                S_MODW: begin
                    if (mod_done) begin
                        r_mod   <= mod_rem;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (fit) begin
                        r_state <= S_RESULT;
                        if (pad != 32'd0 && rest_len != 32'd0) begin
                            if (table_full) begin
                                r_res_status <= ST_FULL;
                            end else begin
                                r_count   <= r_count + CNT_W'(1);
                                r_res_off <= head.start + pad;
                            end
                        end else begin
                            r_res_off <= head.start + pad;
                            if (pad == 32'd0 && rest_len == 32'd0) begin
                                r_count <= r_count - CNT_W'(1);
                            end
                        end
                    end else begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_FSCAN: begin
                    if (r_idx >= r_count) begin
                        r_state <= S_FEND;
                    end else begin
                        if (head.start < r_off) begin
                            r_pos <= r_pos + CNT_W'(1);
                        end
                        if (hit_left) begin
                            r_merged   <= 1'b1;
                            r_last     <= r_idx;
                            r_last_len <= head.len + r_size;
                            r_idx      <= r_idx + CNT_W'(1);
                        end else if (hit_right) begin
                            if (r_merged) begin
                                r_count <= r_count - CNT_W'(1);
                            end
                            r_state <= S_RESULT;
                        end else begin
                            r_idx <= r_idx + CNT_W'(1);
                        end
                    end
                end
                S_FEND: begin
                    if (!r_merged) begin
                        if (table_full) begin
                            r_res_status <= ST_FULL;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    // hold the result until the output register frees up
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid     <= 1'b1;
                        r_status        <= r_res_status;
                        r_result_offset <= (r_res_status == ST_OK) ? r_res_off : 32'd0;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_result_offset = r_result_offset;

endmodule
